[src/ncsg_pkg.sv]
// Shared types, constants and coefficient table for the notch cascade spike guard.
// No dependencies; imported by every module of the block.
package ncsg_pkg;

   // result kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_EVENT  = 1'b1;

   // register index taken from paddr[2]
   localparam logic REG_GUARD   = 1'b0;
   localparam logic REG_LOCKOUT = 1'b1;

   localparam logic [9:0]  GUARD_RESET   = 10'd511;
   localparam logic [15:0] LOCKOUT_RESET = 16'd50;

   localparam int CSR_AW      = 3;
   localparam int QDEPTH      = 4;
   localparam int QAW         = 2;
   localparam int COEF_W      = 16;
   localparam int COEF_SHIFT  = 14;
   localparam int SAMPLE_SHIFT = 12;
   localparam int MAC_STEPS   = 5;

   typedef struct packed {
      logic        kind;
      logic [31:0] stamp;
      logic [9:0]  sample;
   } item_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

   // Q2.14 coefficients per row, in MAC order: b0, b1, b2, -a1, -a2
   localparam logic signed [COEF_W-1:0] COEF_TAB [4][MAC_STEPS] = '{
      '{16'sd15976, -16'sd31420, 16'sd15976, 16'sd31420, -16'sd15568},
      '{16'sd15801, -16'sd29196, 16'sd15801, 16'sd29196, -16'sd15219},
      '{16'sd15801, -16'sd26509, 16'sd15801, 16'sd26509, -16'sd15219},
      '{16'sd15801, -16'sd23170, 16'sd15801, 16'sd23170, -16'sd15219}
   };

   function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] row,
                                                      input logic [2:0] step);
      logic signed [COEF_W-1:0] c;
      c = '0;
      if (step < 3'(MAC_STEPS))
         c = COEF_TAB[row][step];
      return c;
   endfunction

endpackage

[src/notch_cascade_spike_guard_top.sv]
// Top level of the notch cascade spike guard: config registers and block wiring.
// Depends on ncsg_pkg, ncsg_front, ncsg_queue and ncsg_back.
//
// Usage:
//  req_* carries one ADC sample and its millisecond timestamp; rsp_* carries
//  at most one result item per sample: a filtered value (kind 0) or an
//  anomaly event (kind 1, filtered 0). Samples inside the lockout window give
//  no result. The APB port holds guard_threshold at 0x0 and the lockout
//  length in ms at 0x4.
//  The front end classifies an item in its accept cycle and queues it in a
//  four-entry queue; req_stall is high only while that queue is full.
//  The filter engine runs the cascade on one shared multiplier: per stage it
//  steps through the b0, b1, b2, -a1, -a2 products, a drain state and a
//  rounding state, then emits the filtered item to the result register; an
//  event goes to the result register in the cycle after its pop. The engine
//  takes no new item until the current one is in the result register.
//  Reset clears the history, last sample, lockout end and queue and loads
//  the register defaults (511, 50). When rsp_stall is high the result holds;
//  the engine waits with its next result and the queue keeps taking items.
module notch_cascade_spike_guard_top #(
   parameter int STAGES        = 4,
   parameter int HISTORY_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [31:0]                   req_time_ms,
   input  logic [9:0]                    req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_kind,
   output logic signed [31:0]            rsp_filtered,
   output logic [31:0]                   rsp_stamp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ncsg_pkg::CSR_AW-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import ncsg_pkg::*;

   logic [9:0]  guard_ff;
   logic [15:0] lockout_ff;
   logic        csr_write;
   logic        q_push;
   logic        q_pop;
   item_type    q_item;
   item_type    q_head;
   qstat_type   q_stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_ff   <= GUARD_RESET;
         lockout_ff <= LOCKOUT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_GUARD:   guard_ff   <= pwdata[9:0];
            REG_LOCKOUT: lockout_ff <= pwdata[15:0];
            default:     guard_ff   <= guard_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_GUARD:   prdata = {22'd0, guard_ff};
         REG_LOCKOUT: prdata = {16'd0, lockout_ff};
         default:     prdata = '0;
      endcase
   end

   ncsg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_time_ms     (req_time_ms),
      .req_sample      (req_sample),
      .guard_threshold (guard_ff),
      .lockout_len     (lockout_ff),
      .q_stat          (q_stat),
      .q_push          (q_push),
      .q_item          (q_item)
   );

   ncsg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   ncsg_back #(
      .STAGES        (STAGES),
      .HISTORY_WIDTH (HISTORY_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_filtered (rsp_filtered),
      .rsp_stamp    (rsp_stamp)
   );

   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_stat.full))
      else $error("item pushed into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.nonempty)
      else $error("item popped from an empty queue");

   a_event_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_EVENT |-> rsp_filtered == 32'sd0)
      else $error("anomaly event carries a nonzero value");

   a_guard_write: assert property (@(posedge clock) disable iff (reset)
      $past(!reset && csr_write && paddr[2] == REG_GUARD) |->
         guard_ff == $past(pwdata[9:0]))
      else $error("threshold write not taken");

endmodule

[src/ncsg_front.sv]
// Front end: accepts items, applies the lockout window and the jump test.
// Depends on ncsg_pkg; feeds ncsg_queue.
module ncsg_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [31:0]          req_time_ms,
   input  logic [9:0]           req_sample,
   input  logic [9:0]           guard_threshold,
   input  logic [15:0]          lockout_len,
   input  ncsg_pkg::qstat_type  q_stat,
   output logic                 q_push,
   output ncsg_pkg::item_type   q_item
);
   import ncsg_pkg::*;

   logic [9:0]  last_sample_ff;
   logic [31:0] lockout_end_ff;
   logic        accept;
   logic        in_lockout;
   logic [9:0]  jump;
   logic        is_event;

   assign req_stall  = q_stat.full;
   assign accept     = req_valid && !req_stall;
   assign in_lockout = req_time_ms < lockout_end_ff;
   assign jump       = (req_sample > last_sample_ff) ? req_sample - last_sample_ff
                                                     : last_sample_ff - req_sample;
   assign is_event   = jump > guard_threshold;

   assign q_push        = accept && !in_lockout;
   assign q_item.kind   = is_event ? KIND_EVENT : KIND_SAMPLE;
   assign q_item.stamp  = req_time_ms;
   assign q_item.sample = req_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         lockout_end_ff <= '0;
      end else if (q_push) begin
         last_sample_ff <= req_sample;
         if (is_event)
            lockout_end_ff <= req_time_ms + {16'd0, lockout_len};   // wraps mod 2^32
      end
   end

endmodule

[src/ncsg_queue.sv]
// Short item queue between the classifying front end and the filter engine.
// Depends on ncsg_pkg.
module ncsg_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ncsg_pkg::item_type   push_item,
   input  logic                 pop,
   output ncsg_pkg::item_type   head,
   output ncsg_pkg::qstat_type  stat
);
   import ncsg_pkg::*;

   item_type       mem_ff [QDEPTH];
   logic [QAW:0]   wr_ptr_ff;
   logic [QAW:0]   rd_ptr_ff;

   assign stat.nonempty = wr_ptr_ff != rd_ptr_ff;
   assign stat.full     = (wr_ptr_ff[QAW] != rd_ptr_ff[QAW]) &&
                          (wr_ptr_ff[QAW-1:0] == rd_ptr_ff[QAW-1:0]);
   assign head          = mem_ff[rd_ptr_ff[QAW-1:0]];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff[QAW-1:0]] <= push_item;
   end

endmodule

[src/ncsg_back.sv]
// Back end: biquad notch cascade on one shared multiplier, plus the result register.
// Depends on ncsg_pkg; reads items from ncsg_queue.
module ncsg_back #(
   parameter int STAGES        = 4,
   parameter int HISTORY_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ncsg_pkg::qstat_type  q_stat,
   input  ncsg_pkg::item_type   q_head,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_kind,
   output logic signed [31:0]   rsp_filtered,
   output logic [31:0]          rsp_stamp
);
   import ncsg_pkg::*;

   localparam int HW = HISTORY_WIDTH;
   localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int PW = COEF_W + HW;
   localparam logic [2:0] STEP_LAST = 3'(MAC_STEPS - 1);
   localparam logic signed [63:0] HIST_MAX = {{(65-HW){1'b0}}, {(HW-1){1'b1}}};
   localparam logic signed [63:0] HIST_MIN = ~HIST_MAX;
   localparam logic signed [63:0] OUT_MAX  = {{33{1'b0}}, {31{1'b1}}};
   localparam logic signed [63:0] OUT_MIN  = ~OUT_MAX;
   localparam logic signed [63:0] SAT_MAX  = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] SAT_MIN  = ~SAT_MAX;
   localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (COEF_SHIFT - 1);

   typedef enum logic [2:0] {B_IDLE, B_MAC, B_DRAIN, B_ROUND, B_EMIT} bstate_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         s = a[63] ? SAT_MIN : SAT_MAX;
      return s;
   endfunction

   bstate_type                state_ff;
   logic [SW-1:0]             stage_ff;
   logic [2:0]                step_ff;
   logic                      prod_vld_ff;
   logic                      prod_first_ff;
   logic signed [HW-1:0]      hist_ff [STAGES][4];   // x1, x2, y1, y2 per stage
   logic signed [HW-1:0]      x_ff;
   logic signed [63:0]        prod_ff;
   logic signed [63:0]        acc_ff;
   logic [31:0]               stamp_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic signed [31:0]        rsp_filtered_ff;
   logic [31:0]               rsp_stamp_ff;

   logic                      slot_free;
   logic                      rsp_load;
   logic [3:0]                stage_ext;
   logic signed [COEF_W-1:0]  coef_sel;
   logic signed [HW-1:0]      opnd_sel;
   logic signed [PW-1:0]      mul_in;
   logic signed [63:0]        acc_in;
   logic signed [63:0]        round_sum;
   logic signed [63:0]        round_q;
   logic signed [63:0]        y_wide;
   logic signed [HW-1:0]      y_in;
   logic signed [63:0]        x_wide;
   logic signed [63:0]        out_wide;
   logic signed [31:0]        out_in;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == B_IDLE) && q_stat.nonempty && slot_free;

   // result register takes a new item this cycle
   assign rsp_load  = (q_pop && (q_head.kind == KIND_EVENT)) ||
                      ((state_ff == B_EMIT) && slot_free);

   // stage i uses coefficient row i mod 4
   assign stage_ext = 4'(stage_ff);
   assign coef_sel  = coef(stage_ext[1:0], step_ff);

   always_comb begin
      unique case (step_ff)
         3'd0:    opnd_sel = x_ff;
         3'd1:    opnd_sel = hist_ff[stage_ff][0];
         3'd2:    opnd_sel = hist_ff[stage_ff][1];
         3'd3:    opnd_sel = hist_ff[stage_ff][2];
         3'd4:    opnd_sel = hist_ff[stage_ff][3];
         default: opnd_sel = x_ff;
      endcase
   end

   assign mul_in = PW'(coef_sel) * PW'(opnd_sel);
   assign acc_in = prod_first_ff ? prod_ff : sat_add64(acc_ff, prod_ff);

   // round half up, then floor shift
   assign round_sum = sat_add64(acc_ff, ROUND_HALF);
   assign round_q   = round_sum >>> COEF_SHIFT;

   always_comb begin
      if (round_q > HIST_MAX)
         y_wide = HIST_MAX;
      else if (round_q < HIST_MIN)
         y_wide = HIST_MIN;
      else
         y_wide = round_q;
      y_in = y_wide[HW-1:0];
   end

   always_comb begin
      x_wide = 64'(x_ff);
      if (x_wide > OUT_MAX)
         out_wide = OUT_MAX;
      else if (x_wide < OUT_MIN)
         out_wide = OUT_MIN;
      else
         out_wide = x_wide;
      out_in = out_wide[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         stage_ff      <= '0;
         step_ff       <= '0;
         prod_vld_ff   <= 1'b0;
         prod_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int s = 0; s < STAGES; s++) begin
            for (int k = 0; k < 4; k++) begin
               hist_ff[s][k] <= '0;
            end
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (q_pop) begin
                  if (q_head.kind == KIND_EVENT) begin
                     rsp_valid_ff    <= 1'b1;
                     rsp_kind_ff     <= KIND_EVENT;
                     rsp_filtered_ff <= '0;
                     rsp_stamp_ff    <= q_head.stamp;
                  end else begin
                     stage_ff <= '0;
                     step_ff  <= '0;
                     state_ff <= B_MAC;
                  end
               end
            end
            B_MAC: begin
               prod_vld_ff   <= 1'b1;
               prod_first_ff <= step_ff == '0;
               if (step_ff == STEP_LAST)
                  state_ff <= B_DRAIN;
               else
                  step_ff <= step_ff + 3'd1;
            end
            B_DRAIN: begin
               prod_vld_ff <= 1'b0;
               state_ff    <= B_ROUND;
            end
            B_ROUND: begin
               hist_ff[stage_ff][1] <= hist_ff[stage_ff][0];
               hist_ff[stage_ff][0] <= x_ff;
               hist_ff[stage_ff][3] <= hist_ff[stage_ff][2];
               hist_ff[stage_ff][2] <= y_in;
               if (stage_ff == SW'(STAGES - 1)) begin
                  state_ff <= B_EMIT;
               end else begin
                  stage_ff <= stage_ff + 1'b1;
                  step_ff  <= '0;
                  state_ff <= B_MAC;
               end
            end
            B_EMIT: begin
               if (slot_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_kind_ff     <= KIND_SAMPLE;
                  rsp_filtered_ff <= out_in;
                  rsp_stamp_ff    <= stamp_ff;
                  state_ff        <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && q_pop) begin
         x_ff     <= HW'({q_head.sample, {SAMPLE_SHIFT{1'b0}}});
         stamp_ff <= q_head.stamp;
      end else if (state_ff == B_ROUND) begin
         x_ff <= y_in;
      end
      if (state_ff == B_MAC)
         prod_ff <= 64'(mul_in);
      if (prod_vld_ff)
         acc_ff <= acc_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_filtered = rsp_filtered_ff;
   assign rsp_stamp    = rsp_stamp_ff;

endmodule

[test/tb_notch_cascade_spike_guard_top.sv]
// Testbench for notch_cascade_spike_guard_top: directed and random samples
// against an in-bench model of the spike guard and notch cascade.
// Depends on ncsg_pkg and the notch_cascade_spike_guard_top RTL.
`timescale 1ns / 100ps

module tb_notch_cascade_spike_guard_top;
   import ncsg_pkg::*;

   localparam int STAGES        = 4;
   localparam int HISTORY_WIDTH = 32;
   // settle time for a full queue of four items through the cascade, plus margin
   localparam int SETTLE_CYCLES = 200;

   typedef struct packed {
      logic        kind;
      logic [31:0] filtered;
      logic [31:0] stamp;
   } guard_result_type;

   class notch_guard_checker;
      longint           hist [4*STAGES];   // per stage: x1, x2, y1, y2
      logic [9:0]       last_smp;
      logic [31:0]      lock_end;
      logic [9:0]       guard;
      logic [15:0]      lock_len;
      guard_result_type due_results [$];
      int               expected_total;
      int               errors;

      function new();
         foreach (hist[i]) hist[i] = 0;
         last_smp = '0;
         lock_end = '0;
         guard = 10'd511;
         lock_len = 16'd50;
         expected_total = 0;
         errors = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] value);
         if (idx == REG_GUARD) guard = value[9:0];
         else lock_len = value[15:0];
      endfunction

      function bit idle();
         return due_results.size() == 0;
      endfunction

      function void mismatch(string what, longint expv, longint actv);
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, expv, actv);
      endfunction

      function longint sat_add(longint a, longint b);
         longint s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
         return s;
      endfunction

      function longint clamp(longint v, int w);
         longint hi, lo;
         hi = (64'sd1 <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // b2 equals b0 and a1 equals b1 in every row of the notch table
      function logic [31:0] run_cascade(logic [9:0] s);
         longint x, y, acc, b0, b1, a2;
         x = longint'(s) * 4096;
         for (int i = 0; i < STAGES; i++) begin
            case (i % 4)
               0: begin b0 = 15976; b1 = -31420; a2 = 15568; end
               1: begin b0 = 15801; b1 = -29196; a2 = 15219; end
               2: begin b0 = 15801; b1 = -26509; a2 = 15219; end
               default: begin b0 = 15801; b1 = -23170; a2 = 15219; end
            endcase
            acc = b0 * x;
            acc = sat_add(acc, b1 * hist[4*i]);
            acc = sat_add(acc, b0 * hist[4*i+1]);
            acc = sat_add(acc, -(b1 * hist[4*i+2]));
            acc = sat_add(acc, -(a2 * hist[4*i+3]));
            // round half up, then floor shift
            y = clamp(sat_add(acc, 64'sd8192) >>> 14, HISTORY_WIDTH);
            hist[4*i+1] = hist[4*i];
            hist[4*i]   = x;
            hist[4*i+3] = hist[4*i+2];
            hist[4*i+2] = y;
            x = y;
         end
         x = clamp(x, 32);
         return x[31:0];
      endfunction

      function void note_sample(logic [31:0] t, logic [9:0] s);
         guard_result_type r;
         logic [9:0] jump;
         if (t < lock_end) return;   // still locked out, item dropped
         jump = (s > last_smp) ? s - last_smp : last_smp - s;
         r.stamp = t;
         if (jump > guard) begin
            lock_end = t + lock_len;
            r.kind = KIND_EVENT;
            r.filtered = '0;
         end else begin
            r.kind = KIND_SAMPLE;
            r.filtered = run_cascade(s);
         end
         last_smp = s;
         due_results.push_back(r);
         expected_total++;
      endfunction

      function void check_result(logic kind, logic [31:0] filt, logic [31:0] stamp);
         guard_result_type e;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got kind %0d",
                     $time, kind, " filtered %0d stamp %0h", $signed(filt), stamp);
            return;
         end
         e = due_results.pop_front();
         if (kind !== e.kind) mismatch("kind", e.kind, kind);
         if (filt !== e.filtered)
            mismatch("filtered", longint'($signed(e.filtered)), longint'($signed(filt)));
         if (stamp !== e.stamp) mismatch("stamp", e.stamp, stamp);
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [31:0]              req_time_ms;
   logic [9:0]               req_sample;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_kind;
   logic signed [31:0]       rsp_filtered;
   logic [31:0]              rsp_stamp;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_AW-1:0]        paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   notch_cascade_spike_guard_top #(
      .STAGES(STAGES),
      .HISTORY_WIDTH(HISTORY_WIDTH)
   ) u_dut (.*);

   notch_guard_checker sb = new();

   logic [31:0] now_ms;
   int          level;
   bit          send_calm;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // accepted items on both channels, sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_kind, rsp_filtered, rsp_stamp);
         if (req_valid && !req_stall) sb.note_sample(req_time_ms, req_sample);
      end
   end

   // result side: stall for a random count after each accepted item
   initial begin
      int hold;
      bit calm;
      hold = 0;
      calm = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!reset && rsp_valid && !rsp_stall) begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            hold = calm ? 0 : $urandom_range(0, 6);
         end
         rsp_stall <= (hold > 0);
      end
   end

   task automatic send_sample(logic [31:0] t, logic [9:0] s);
      int gap;
      if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_time_ms <= t;
      req_sample  <= s;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, value);
      // read back through the same port
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== value) sb.mismatch("register readback", value, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // hold the sender until every result is out and the engine has gone quiet
   task automatic start_phase(logic [9:0] g, logic [15:0] l);
      req_valid <= 1'b0;
      while (!sb.idle()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(REG_GUARD, {22'd0, g});
      csr_write(REG_LOCKOUT, {16'd0, l});
   endtask

   task automatic run_directed();
      send_sample(32'd0, 10'd0);
      send_sample(32'd4, 10'd511);          // jump equal to threshold passes
      send_sample(32'd8, 10'd1023);         // anomaly, locked until 58
      send_sample(32'd12, 10'd1023);        // dropped
      send_sample(32'd57, 10'd0);           // last locked ms, dropped
      send_sample(32'd58, 10'd1023);
      send_sample(32'd62, 10'd1023);
      send_sample(32'd66, 10'd512);         // jump 511
      send_sample(32'd70, 10'd0);           // jump 512, anomaly
      send_sample(32'd119, 10'd0);
      send_sample(32'd120, 10'd0);
      send_sample(32'd124, 10'h155);
      send_sample(32'd128, 10'h2AA);
      send_sample(32'hFFFF_FFE0, 10'h2AA);
      send_sample(32'hFFFF_FFF0, 10'd0);    // anomaly, lockout end wraps to 0x22
      send_sample(32'hFFFF_FFF4, 10'd0);    // above the wrapped end: passes
      send_sample(32'h0000_0000, 10'd0);    // dropped
      send_sample(32'h0000_0021, 10'd0);    // dropped
      send_sample(32'h0000_0022, 10'd0);
      send_sample(32'hFFFF_FFFF, 10'd1023); // anomaly at max stamp
      send_sample(32'h7FFF_FFFF, 10'd1023);
      send_sample(32'h8000_0000, 10'd1022);
   endtask

   // mostly a slow signal sampled every 1 to 8 ms, with spikes, time jumps and noise
   task automatic run_random(int count);
      int sent, base, pick;
      logic [9:0] s;
      sent = 0;
      base = sb.expected_total;
      while (sent < count || (sb.expected_total - base < 40 && sent < 2 * count)) begin
         pick = $urandom_range(0, 99);
         level += int'($urandom_range(0, 24)) - 12;
         if (level < 0) level = 0;
         if (level > 1023) level = 1023;
         if (pick < 5) now_ms = $urandom;
         else if (pick < 12) now_ms += $urandom_range(0, 70000);
         else now_ms += $urandom_range(1, 8);
         s = level[9:0];
         if (pick >= 88 || pick < 5) s = $urandom_range(0, 1023);
         send_sample(now_ms, s);
         sent++;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_time_ms = '0;
      req_sample  = '0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      send_calm   = 1'b0;
      now_ms      = 32'd1000;
      level       = 512;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(150);
      start_phase(10'd0, 16'd0);
      run_random(200);
      start_phase(10'd1023, 16'd65535);
      run_random(200);
      start_phase(10'd1, 16'd1);
      run_random(200);
      start_phase(10'd40, 16'd65535);
      run_random(150);
      start_phase(10'($urandom_range(2, 1022)), 16'($urandom_range(0, 300)));
      run_random(150);
      start_phase(10'd511, 16'd50);
      run_random(150);

      req_valid <= 1'b0;
      while (!sb.idle()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_notch_cascade_spike_guard_top: done, clean");
      else
         $display("tb_notch_cascade_spike_guard_top: done, errors");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("tb_notch_cascade_spike_guard_top: done, errors");
      $finish;
   end

endmodule

[notch_cascade_spike_guard_top.f]
src/ncsg_pkg.sv
src/ncsg_front.sv
src/ncsg_queue.sv
src/ncsg_back.sv
src/notch_cascade_spike_guard_top.sv
test/tb_notch_cascade_spike_guard_top.sv
